// File: src/dlf_pkg.sv
// Package for the degree-limited forest builder: command codes, field widths
// and the sequencer state type. No dependencies.
`default_nettype none
package dlf_pkg;

    localparam int CMD_W  = 2;
    localparam int VTX_W  = 7;
    localparam int COST_W = 16;
    localparam int SUM_W  = 22;
    localparam int DEG_W  = 6;
    localparam int CNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD_RDA,
        ST_ADD_RDB,
        ST_ADD_CHK,
        ST_ADD_INCB,
        ST_MERGE,
        ST_MERGE_DRAIN,
        ST_RM_POP,
        ST_RM_DECA,
        ST_RM_DECB,
        ST_RM_DECW,
        ST_RELABEL,
        ST_RP_RD,
        ST_RP_LA,
        ST_RP_LB,
        ST_RP_KEEP,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// File: src/dlf_if.sv
// Channel interfaces for the forest builder: command, result and config words.
// Depends on dlf_pkg.
`default_nettype none
interface dlf_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [dlf_pkg::CMD_W-1:0]  cmd;
    logic [dlf_pkg::VTX_W-1:0]  vertex_a;
    logic [dlf_pkg::VTX_W-1:0]  vertex_b;
    logic [dlf_pkg::COST_W-1:0] edge_cost;
    modport source (output valid, cmd, vertex_a, vertex_b, edge_cost, input ready);
    modport sink   (input valid, cmd, vertex_a, vertex_b, edge_cost, output ready);
endinterface

interface dlf_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [dlf_pkg::SUM_W-1:0] total_cost;
    logic [dlf_pkg::CNT_W-1:0] edge_count;
    modport source (output valid, accepted, total_cost, edge_count, input ready);
    modport sink   (input valid, accepted, total_cost, edge_count, output ready);
endinterface

interface dlf_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [dlf_pkg::DEG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: src/dlf_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module dlf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/degree_limited_forest_builder.sv
// An accepted add ends with one label sweep; a clear reruns the init sweep. A remove that pops
// an edge relabels every vertex, then replays every remaining stored edge, one label sweep per
// edge, through the single label memory read port.
// Throughput: one word at a time; the next is taken in the cycle after the result loads, later
// while the result waits. Reset: asynchronous, active low; a sweep then sets degrees to zero and
// labels to zero-based vertex indices, command ready stays low. Uses dlf_pkg, dlf_if, dlf_ram.
`default_nettype none
module degree_limited_forest_builder #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlf_cfg_if.sink     cfg,
    dlf_cmd_if.sink     cmd_ch,
    dlf_rsp_if.source   rsp_ch
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int SW = 2 * VW + dlf_pkg::COST_W;
    localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

    dlf_pkg::state_t state_reg, state_next;

    logic [VW-1:0]              idx_reg, idx_next;
    logic [VW-1:0]              k_reg, k_next;
    logic [dlf_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [dlf_pkg::VTX_W-1:0]  va_reg, va_next;
    logic [dlf_pkg::VTX_W-1:0]  vb_reg, vb_next;
    logic [dlf_pkg::COST_W-1:0] cin_reg, cin_next;
    logic [dlf_pkg::DEG_W-1:0]  deg_a_reg, deg_a_next;
    logic [dlf_pkg::DEG_W-1:0]  deg_b_reg, deg_b_next;
    logic [VW-1:0]              keep_reg, keep_next;
    logic [VW-1:0]              gone_reg, gone_next;
    logic [VW-1:0]              top_b_reg, top_b_next;
    logic [VW-1:0]              cnt_reg, cnt_next;
    logic [dlf_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [dlf_pkg::DEG_W-1:0]  lim_reg, lim_next;
    logic                       rep_reg, rep_next;
    logic                       acc_reg, acc_next;
    logic                       boot_reg, boot_next;
    logic                       mp_vld_reg, mp_vld_next;
    logic [VW-1:0]              mp_addr_reg, mp_addr_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_acc_reg, out_acc_next;
    logic [dlf_pkg::SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic [VW-1:0]              out_cnt_reg, out_cnt_next;

    // memory ports
    logic                      deg_we, lbl_we, st_we;
    logic [VW-1:0]             deg_waddr, deg_raddr, lbl_waddr, lbl_raddr, st_raddr;
    logic [dlf_pkg::DEG_W-1:0] deg_wdata, deg_rdata;
    logic [VW-1:0]             lbl_wdata, lbl_rdata;
    logic [SW-1:0]             st_wdata, st_rdata;

    logic [VW-1:0]             a_idx, b_idx, st_a, st_b;
    logic [dlf_pkg::COST_W-1:0] st_cost;
    logic                      bad_add, add_ok, accept, out_free, last_idx;

    assign a_idx    = VW'(int'(va_reg) - 1);
    assign b_idx    = VW'(int'(vb_reg) - 1);
    assign st_a     = st_rdata[SW-1 -: VW];
    assign st_b     = st_rdata[dlf_pkg::COST_W +: VW];
    assign st_cost  = st_rdata[dlf_pkg::COST_W-1:0];
    assign bad_add  = (va_reg == '0) || (int'(va_reg) > MAX_VERTICES)
                   || (vb_reg == '0) || (int'(vb_reg) > MAX_VERTICES)
                   || (cnt_reg == LAST_V);
    assign add_ok   = (deg_a_reg < lim_reg) && (deg_rdata < lim_reg)
                   && (keep_reg != lbl_rdata);
    assign accept   = cmd_ch.valid && cmd_ch.ready;
    assign out_free = !out_valid_reg || rsp_ch.ready;
    assign last_idx = (idx_reg == LAST_V);

    assign cmd_ch.ready     = (state_reg == dlf_pkg::ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp_ch.valid     = out_valid_reg;
    assign rsp_ch.accepted  = out_acc_reg;
    assign rsp_ch.total_cost = out_sum_reg;
    assign rsp_ch.edge_count = dlf_pkg::CNT_W'(out_cnt_reg);

    dlf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(dlf_pkg::DEG_W), .AW(VW)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    dlf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW), .AW(VW)) u_lbl (
        .clk(clk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
        .raddr(lbl_raddr), .rdata(lbl_rdata)
    );

    dlf_ram #(.DEPTH(MAX_VERTICES - 1), .WIDTH(SW), .AW(VW)) u_stack (
        .clk(clk), .we(st_we), .waddr(cnt_reg), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlf_pkg::ST_INIT:
            begin
                if (last_idx)
                begin
                    state_next = boot_reg ? dlf_pkg::ST_IDLE : dlf_pkg::ST_OUT;
                end
            end
            dlf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (dlf_pkg::cmd_t'(cmd_ch.cmd))
                        dlf_pkg::CMD_ADD:    state_next = dlf_pkg::ST_ADD_RDA;
                        dlf_pkg::CMD_REMOVE: state_next = dlf_pkg::ST_RM_POP;
                        dlf_pkg::CMD_CLEAR:  state_next = dlf_pkg::ST_INIT;
                        default:             state_next = dlf_pkg::ST_OUT;
                    endcase
                end
            end
            dlf_pkg::ST_ADD_RDA:
                state_next = bad_add ? dlf_pkg::ST_OUT : dlf_pkg::ST_ADD_RDB;
            dlf_pkg::ST_ADD_RDB:  state_next = dlf_pkg::ST_ADD_CHK;
            dlf_pkg::ST_ADD_CHK:
                state_next = add_ok ? dlf_pkg::ST_ADD_INCB : dlf_pkg::ST_OUT;
            dlf_pkg::ST_ADD_INCB: state_next = dlf_pkg::ST_MERGE;
            dlf_pkg::ST_MERGE:
            begin
                if (last_idx)
                begin
                    state_next = dlf_pkg::ST_MERGE_DRAIN;
                end
            end
            dlf_pkg::ST_MERGE_DRAIN:
            begin
                if (rep_reg && ({1'b0, k_reg} + 1'b1 < {1'b0, cnt_reg}))
                begin
                    state_next = dlf_pkg::ST_RP_RD;
                end
                else
                begin
                    state_next = dlf_pkg::ST_OUT;
                end
            end
            dlf_pkg::ST_RM_POP:
                state_next = (cnt_reg == '0) ? dlf_pkg::ST_OUT : dlf_pkg::ST_RM_DECA;
            dlf_pkg::ST_RM_DECA: state_next = dlf_pkg::ST_RM_DECB;
            dlf_pkg::ST_RM_DECB: state_next = dlf_pkg::ST_RM_DECW;
            dlf_pkg::ST_RM_DECW: state_next = dlf_pkg::ST_RELABEL;
            dlf_pkg::ST_RELABEL:
            begin
                if (last_idx)
                begin
                    state_next = (cnt_reg == '0) ? dlf_pkg::ST_OUT : dlf_pkg::ST_RP_RD;
                end
            end
            dlf_pkg::ST_RP_RD:   state_next = dlf_pkg::ST_RP_LA;
            dlf_pkg::ST_RP_LA:   state_next = dlf_pkg::ST_RP_LB;
            dlf_pkg::ST_RP_LB:   state_next = dlf_pkg::ST_RP_KEEP;
            dlf_pkg::ST_RP_KEEP: state_next = dlf_pkg::ST_MERGE;
            dlf_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = dlf_pkg::ST_IDLE;
                end
            end
            default: state_next = dlf_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next       = idx_reg;
        k_next         = k_reg;
        cmd_next       = cmd_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        cin_next       = cin_reg;
        deg_a_next     = deg_a_reg;
        deg_b_next     = deg_b_reg;
        keep_next      = keep_reg;
        gone_next      = gone_reg;
        top_b_next     = top_b_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        lim_next       = (cfg.valid && cfg.ready) ? cfg.data : lim_reg;
        rep_next       = rep_reg;
        acc_next       = acc_reg;
        boot_next      = boot_reg;
        mp_vld_next    = 1'b0;
        mp_addr_next   = mp_addr_reg;
        out_valid_next = out_valid_reg && !rsp_ch.ready;
        out_acc_next   = out_acc_reg;
        out_sum_next   = out_sum_reg;
        out_cnt_next   = out_cnt_reg;

        deg_we    = 1'b0;
        deg_waddr = idx_reg;
        deg_wdata = '0;
        deg_raddr = a_idx;
        lbl_we    = 1'b0;
        lbl_waddr = idx_reg;
        lbl_wdata = idx_reg;
        lbl_raddr = a_idx;
        st_we     = 1'b0;
        st_wdata  = {a_idx, b_idx, cin_reg};
        st_raddr  = k_reg;

        unique case (state_reg)
            dlf_pkg::ST_INIT:
            begin
                deg_we   = 1'b1;
                lbl_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    boot_next = 1'b0;
                    idx_next  = '0;
                end
            end
            dlf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_ch.cmd;
                    va_next  = cmd_ch.vertex_a;
                    vb_next  = cmd_ch.vertex_b;
                    cin_next = cmd_ch.edge_cost;
                    acc_next = 1'b0;
                    rep_next = 1'b0;
                    idx_next = '0;
                    if (dlf_pkg::cmd_t'(cmd_ch.cmd) == dlf_pkg::CMD_CLEAR)
                    begin
                        acc_next = 1'b1;
                        cnt_next = '0;
                        sum_next = '0;
                    end
                end
            end
            dlf_pkg::ST_ADD_RDA:
            begin
                deg_raddr = a_idx;
                lbl_raddr = a_idx;
            end
            dlf_pkg::ST_ADD_RDB:
            begin
                deg_a_next = deg_rdata;
                keep_next  = lbl_rdata;
                deg_raddr  = b_idx;
                lbl_raddr  = b_idx;
            end
            dlf_pkg::ST_ADD_CHK:
            begin
                if (add_ok)
                begin
                    st_we      = 1'b1;
                    deg_we     = 1'b1;
                    deg_waddr  = a_idx;
                    deg_wdata  = deg_a_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    sum_next   = sum_reg + dlf_pkg::SUM_W'(cin_reg);
                    acc_next   = 1'b1;
                    deg_b_next = deg_rdata;
                    gone_next  = lbl_rdata;
                end
            end
            dlf_pkg::ST_ADD_INCB:
            begin
                deg_we    = 1'b1;
                deg_waddr = b_idx;
                deg_wdata = deg_b_reg + 1'b1;
                idx_next  = '0;
            end
            dlf_pkg::ST_MERGE:
            begin
                // read one label per cycle, rewrite the one read in the previous cycle
                lbl_raddr    = idx_reg;
                mp_vld_next  = 1'b1;
                mp_addr_next = idx_reg;
                lbl_we       = mp_vld_reg && (lbl_rdata == gone_reg);
                lbl_waddr    = mp_addr_reg;
                lbl_wdata    = keep_reg;
                idx_next     = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next = '0;
                end
            end
            dlf_pkg::ST_MERGE_DRAIN:
            begin
                lbl_we    = mp_vld_reg && (lbl_rdata == gone_reg);
                lbl_waddr = mp_addr_reg;
                lbl_wdata = keep_reg;
                k_next    = k_reg + 1'b1;
            end
            dlf_pkg::ST_RM_POP:
            begin
                st_raddr = cnt_reg - 1'b1;
            end
            dlf_pkg::ST_RM_DECA:
            begin
                top_b_next = st_b;
                sum_next   = sum_reg - dlf_pkg::SUM_W'(st_cost);
                cnt_next   = cnt_reg - 1'b1;
                deg_raddr  = st_a;
                mp_addr_next = st_a;
                acc_next   = 1'b1;
                rep_next   = 1'b1;
            end
            dlf_pkg::ST_RM_DECB:
            begin
                deg_we    = 1'b1;
                deg_waddr = mp_addr_reg;
                deg_wdata = deg_rdata - 1'b1;
                deg_raddr = top_b_reg;
            end
            dlf_pkg::ST_RM_DECW:
            begin
                deg_we    = 1'b1;
                deg_waddr = top_b_reg;
                deg_wdata = deg_rdata - 1'b1;
                idx_next  = '0;
                k_next    = '0;
            end
            dlf_pkg::ST_RELABEL:
            begin
                lbl_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next = '0;
                end
            end
            dlf_pkg::ST_RP_RD:
            begin
                st_raddr = k_reg;
            end
            dlf_pkg::ST_RP_LA:
            begin
                lbl_raddr  = st_a;
                top_b_next = st_b;
            end
            dlf_pkg::ST_RP_LB:
            begin
                keep_next = lbl_rdata;
                lbl_raddr = top_b_reg;
            end
            dlf_pkg::ST_RP_KEEP:
            begin
                gone_next = lbl_rdata;
                idx_next  = '0;
            end
            dlf_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_sum_next   = sum_reg;
                    out_cnt_next   = cnt_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlf_pkg::ST_INIT;
            idx_reg       <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            lim_reg       <= dlf_pkg::DEG_W'(2);
            rep_reg       <= 1'b0;
            acc_reg       <= 1'b0;
            boot_reg      <= 1'b1;
            mp_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            lim_reg       <= lim_next;
            rep_reg       <= rep_next;
            acc_reg       <= acc_next;
            boot_reg      <= boot_next;
            mp_vld_reg    <= mp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        cin_reg     <= cin_next;
        deg_a_reg   <= deg_a_next;
        deg_b_reg   <= deg_b_next;
        keep_reg    <= keep_next;
        gone_reg    <= gone_next;
        top_b_reg   <= top_b_next;
        mp_addr_reg <= mp_addr_next;
        out_acc_reg <= out_acc_next;
        out_sum_reg <= out_sum_next;
        out_cnt_reg <= out_cnt_next;
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> cnt_reg != LAST_V)
        else $error("edge pushed on a full stack");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != dlf_pkg::ST_IDLE)
        else $error("sequencer idle right after taking a word");

    a_add_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlf_pkg::ST_ADD_CHK && add_ok) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("accepted edge did not raise the stack count");
`endif

endmodule
`default_nettype wire
